FILE: sv/bln_pkg.sv
`timescale 1ns / 1ps
// bln_pkg: request and response payload types, function codes and the line
// mode flags shared by the line generator modules. No dependencies.
package bln_pkg;

   // fixed widths of the channel fields
   localparam int unsigned PIX_BITS   = 8;
   localparam int unsigned COLOR_BITS = 16;

   // request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_NEXT  = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [PIX_BITS-1:0]   x_start;
      logic [PIX_BITS-1:0]   y_start;
      logic [PIX_BITS-1:0]   x_end;
      logic [PIX_BITS-1:0]   y_end;
      logic [COLOR_BITS-1:0] pixel_color;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]   out_x;
      logic [PIX_BITS-1:0]   out_y;
      logic [COLOR_BITS-1:0] out_color;
      logic                  last_pixel;
      logic                  degenerate_error;
   } rsp_payload_type;

   typedef struct packed {
      logic major_is_x;
      logic minor_step_negative;
   } line_mode_type;

endpackage

FILE: sv/bln_setup.sv
`timescale 1ns / 1ps
// bln_setup: decodes a start request into the initial line state (axis choice,
// endpoint ordering, spans and decision term). Depends on bln_pkg.
module bln_setup #(
   parameter int unsigned COORD_BITS = 8
) (
   input  bln_pkg::req_payload_type     req,
   output bln_pkg::line_mode_type       mode,
   output logic                         degenerate,
   output logic [COORD_BITS-1:0]        major_pos,
   output logic [COORD_BITS-1:0]        minor_pos,
   output logic [COORD_BITS-1:0]        pixels_left,
   output logic [COORD_BITS:0]          twice_major_span,
   output logic [COORD_BITS:0]          twice_minor_span,
   output logic [COORD_BITS+2:0]        error_term
);
   import bln_pkg::*;

   localparam int unsigned ErrBits = COORD_BITS + 3;

   logic [COORD_BITS-1:0] xs, ys, xe, ye;
   logic [COORD_BITS-1:0] span_x, span_y;
   logic [COORD_BITS-1:0] mj0, mn0, mn1, span_mj, span_mn;
   logic                  x_major;

   assign xs = COORD_BITS'(req.x_start);
   assign ys = COORD_BITS'(req.y_start);
   assign xe = COORD_BITS'(req.x_end);
   assign ye = COORD_BITS'(req.y_end);

   assign span_x = (xs > xe) ? (xs - xe) : (xe - xs);
   assign span_y = (ys > ye) ? (ys - ye) : (ye - ys);

   // ties go to the y axis
   assign x_major = (span_x > span_y);

   always_comb begin
      if (x_major) begin
         span_mj = span_x;
         span_mn = span_y;
         if (xs > xe) begin
            mj0 = xe; mn0 = ye; mn1 = ys;
         end else begin
            mj0 = xs; mn0 = ys; mn1 = ye;
         end
      end else begin
         span_mj = span_y;
         span_mn = span_x;
         if (ys > ye) begin
            mj0 = ye; mn0 = xe; mn1 = xs;
         end else begin
            mj0 = ys; mn0 = xs; mn1 = xe;
         end
      end
   end

   assign mode.major_is_x          = x_major;
   assign mode.minor_step_negative = !(mn1 > mn0);
   assign degenerate               = (span_mj == '0);
   assign major_pos                = mj0;
   assign minor_pos                = mn0;
   assign pixels_left              = span_mj;
   assign twice_major_span         = {span_mj, 1'b0};
   assign twice_minor_span         = {span_mn, 1'b0};
   assign error_term = ErrBits'({span_mn, 1'b0}) - ErrBits'(span_mj);

endmodule

FILE: sv/bln_stepper.sv
`timescale 1ns / 1ps
// bln_stepper: forms the current pixel from the line state and computes the
// state for the following pixel (one Bresenham step). Depends on bln_pkg.
module bln_stepper #(
   parameter int unsigned COORD_BITS = 8
) (
   input  bln_pkg::line_mode_type               mode,
   input  logic [COORD_BITS-1:0]                major_pos,
   input  logic [COORD_BITS-1:0]                minor_pos,
   input  logic [COORD_BITS-1:0]                pixels_left,
   input  logic [COORD_BITS:0]                  twice_major_span,
   input  logic [COORD_BITS:0]                  twice_minor_span,
   input  logic [COORD_BITS+2:0]                error_term,
   output logic [bln_pkg::PIX_BITS-1:0]         pix_x,
   output logic [bln_pkg::PIX_BITS-1:0]         pix_y,
   output logic                                 last,
   output logic [COORD_BITS-1:0]                major_pos_next,
   output logic [COORD_BITS-1:0]                minor_pos_next,
   output logic [COORD_BITS-1:0]                pixels_left_next,
   output logic [COORD_BITS+2:0]                error_term_next
);
   import bln_pkg::*;

   localparam int unsigned ErrBits = COORD_BITS + 3;

   logic                minor_moves;
   logic [ErrBits-1:0]  major_drop;

   assign pix_x = PIX_BITS'(mode.major_is_x ? major_pos : minor_pos);
   assign pix_y = PIX_BITS'(mode.major_is_x ? minor_pos : major_pos);
   assign last  = (pixels_left == '0);

   // decision term not negative: step along the minor axis
   assign minor_moves = !error_term[ErrBits-1];
   assign major_drop  = minor_moves ? ErrBits'(twice_major_span) : '0;

   always_comb begin
      if (!minor_moves) begin
         minor_pos_next = minor_pos;
      end else if (mode.minor_step_negative) begin
         minor_pos_next = minor_pos - COORD_BITS'(1);
      end else begin
         minor_pos_next = minor_pos + COORD_BITS'(1);
      end
   end

   assign error_term_next  = error_term - major_drop + ErrBits'(twice_minor_span);
   assign major_pos_next   = major_pos + COORD_BITS'(1);
   assign pixels_left_next = pixels_left - COORD_BITS'(1);

endmodule

FILE: sv/bresenham_line_generator.sv
`timescale 1ns / 1ps
// Bresenham line generator, one pixel per clock while the receiver keeps up.
// Request channel (req_*): func = start loads two endpoints and a colour and
// returns nothing, except when the endpoints coincide, which returns a single
// response with degenerate_error set and all other fields zero. func = next
// returns the next pixel of the active line; the far endpoint is flagged with
// last_pixel, after which the line is idle and next requests are dropped
// silently. A start while a line is active abandons that line.
// Response channel (rsp_*): a registered output stage. A request that gives a
// response shows it on rsp_* in the cycle after it is taken.
// Throughput: one request per cycle. req_ready is high whenever the output
// stage is empty or is being emptied in the same cycle, so a stalled receiver
// holds back the request side only while a response is waiting.
// Reset: synchronous; the line goes idle and the output stage empties.
// Depends on bln_pkg, bln_setup and bln_stepper.
module bresenham_line_generator #(
   parameter int unsigned COORD_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bln_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bln_pkg::rsp_payload_type rsp_payload
);
   import bln_pkg::*;

   localparam int unsigned ErrBits = COORD_BITS + 3;

   // line state
   logic                  line_active_ff, line_active_in;
   line_mode_type         mode_ff, mode_in;
   logic [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0] pixels_left_ff, pixels_left_in;
   logic [ErrBits-1:0]    error_term_ff, error_term_in;
   logic [COORD_BITS:0]   twice_major_ff, twice_major_in;
   logic [COORD_BITS:0]   twice_minor_ff, twice_minor_in;
   logic [COLOR_BITS-1:0] line_color_ff, line_color_in;

   // output stage
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  req_accept;

   // setup results
   line_mode_type         su_mode;
   logic                  su_degenerate;
   logic [COORD_BITS-1:0] su_major_pos, su_minor_pos, su_pixels_left;
   logic [COORD_BITS:0]   su_twice_major, su_twice_minor;
   logic [ErrBits-1:0]    su_error_term;

   // stepper results
   logic [PIX_BITS-1:0]   st_x, st_y;
   logic                  st_last;
   logic [COORD_BITS-1:0] st_major_pos, st_minor_pos, st_pixels_left;
   logic [ErrBits-1:0]    st_error_term;

   bln_setup #(
      .COORD_BITS(COORD_BITS)
   ) u_setup (
      .req              (req_payload),
      .mode             (su_mode),
      .degenerate       (su_degenerate),
      .major_pos        (su_major_pos),
      .minor_pos        (su_minor_pos),
      .pixels_left      (su_pixels_left),
      .twice_major_span (su_twice_major),
      .twice_minor_span (su_twice_minor),
      .error_term       (su_error_term)
   );

   bln_stepper #(
      .COORD_BITS(COORD_BITS)
   ) u_stepper (
      .mode             (mode_ff),
      .major_pos        (major_pos_ff),
      .minor_pos        (minor_pos_ff),
      .pixels_left      (pixels_left_ff),
      .twice_major_span (twice_major_ff),
      .twice_minor_span (twice_minor_ff),
      .error_term       (error_term_ff),
      .pix_x            (st_x),
      .pix_y            (st_y),
      .last             (st_last),
      .major_pos_next   (st_major_pos),
      .minor_pos_next   (st_minor_pos),
      .pixels_left_next (st_pixels_left),
      .error_term_next  (st_error_term)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      line_active_in = line_active_ff;
      mode_in        = mode_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      pixels_left_in = pixels_left_ff;
      error_term_in  = error_term_ff;
      twice_major_in = twice_major_ff;
      twice_minor_in = twice_minor_ff;
      line_color_in  = line_color_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      if (req_accept) begin
         if (req_payload.func == FUNC_START) begin
            line_color_in = req_payload.pixel_color;
            if (su_degenerate) begin
               line_active_in = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '0;
               rsp_payload_in.degenerate_error = 1'b1;
            end else begin
               line_active_in = 1'b1;
               mode_in        = su_mode;
               major_pos_in   = su_major_pos;
               minor_pos_in   = su_minor_pos;
               pixels_left_in = su_pixels_left;
               error_term_in  = su_error_term;
               twice_major_in = su_twice_major;
               twice_minor_in = su_twice_minor;
            end
         end else if (line_active_ff) begin
            rsp_valid_in                    = 1'b1;
            rsp_payload_in.out_x            = st_x;
            rsp_payload_in.out_y            = st_y;
            rsp_payload_in.out_color        = line_color_ff;
            rsp_payload_in.last_pixel       = st_last;
            rsp_payload_in.degenerate_error = 1'b0;
            if (st_last) begin
               line_active_in = 1'b0;
            end else begin
               major_pos_in   = st_major_pos;
               minor_pos_in   = st_minor_pos;
               pixels_left_in = st_pixels_left;
               error_term_in  = st_error_term;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      pixels_left_ff <= pixels_left_in;
      error_term_ff  <= error_term_in;
      twice_major_ff <= twice_major_in;
      twice_minor_ff <= twice_minor_in;
      line_color_ff  <= line_color_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a coincident-endpoint response carries no pixel
   a_degenerate_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.degenerate_error) |->
      (rsp_payload_ff.out_x == '0 && rsp_payload_ff.out_y == '0 &&
       rsp_payload_ff.out_color == '0 && !rsp_payload_ff.last_pixel))
      else $error("degenerate response carries pixel data");

   // the final pixel ends the line
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.func == FUNC_NEXT && line_active_ff &&
       pixels_left_ff == '0) |=> (!line_active_ff && rsp_valid_ff &&
       rsp_payload_ff.last_pixel))
      else $error("final pixel did not close the line");

   // a next request on an active line always produces a response
   a_next_responds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.func == FUNC_NEXT && line_active_ff) |=>
      (rsp_valid_ff && !rsp_payload_ff.degenerate_error))
      else $error("pixel request lost");

   // a proper start activates the line without a response of its own
   a_start_activates: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.func == FUNC_START && !su_degenerate) |=>
      (line_active_ff && (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready))))
      else $error("start request handled incorrectly");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for bresenham_line_generator. A directed table and
// constrained-random line sequences are checked against a pixel predictor or the
// table's fixed responses. Depends on bln_pkg and bresenham_line_generator.
module tb_top;
   import bln_pkg::*;

   localparam int unsigned TARGET_REQUESTS = 1550;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned HOLD_START      = 600;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned DRAIN_CYCLES    = 20;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_FIXED
   } row_kind_type;

   typedef struct packed {
      req_payload_type req;
      row_kind_type    kind;
      rsp_payload_type rsp;
   } dir_row_type;

   localparam rsp_payload_type NO_PIXEL   = '0;
   localparam rsp_payload_type DEGENERATE = {8'h00, 8'h00, 16'h0000, 1'b0, 1'b1};

   localparam int unsigned NUM_ROWS = 26;

   dir_row_type directed_rows [NUM_ROWS] = '{
      // next straight after reset does nothing
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_NONE, NO_PIXEL},
      // coincident endpoints, mid range and top corner
      {{FUNC_START, 8'h05, 8'h05, 8'h05, 8'h05, 16'h1234}, ROW_FIXED, DEGENERATE},
      {{FUNC_START, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff}, ROW_FIXED, DEGENERATE},
      // two pixel line, all fields readable by eye
      {{FUNC_START, 8'h00, 8'h00, 8'h01, 8'h00, 16'hffff}, ROW_NONE, NO_PIXEL},
      {{FUNC_NEXT,  8'hff, 8'hff, 8'hff, 8'hff, 16'h0000}, ROW_FIXED,
       {8'h00, 8'h00, 16'hffff, 1'b0, 1'b0}},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_FIXED,
       {8'h01, 8'h00, 16'hffff, 1'b1, 1'b0}},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_NONE, NO_PIXEL},
      // full diagonal, tie goes to y, minor steps down
      {{FUNC_START, 8'hff, 8'h00, 8'h00, 8'hff, 16'ha5a5}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      // start while active abandons the diagonal
      {{FUNC_START, 8'hff, 8'h80, 8'h00, 8'h7f, 16'h5a5a}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      // vertical and horizontal extremes
      {{FUNC_START, 8'h00, 8'h00, 8'h00, 8'hff, 16'h8000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_START, 8'h00, 8'hff, 8'hff, 8'hff, 16'h0001}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      // coincident start while a line is active leaves the block idle
      {{FUNC_START, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_FIXED, DEGENERATE},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_NONE, NO_PIXEL},
      // short x-major line given right to left, drawn left to right, minor steps down
      {{FUNC_START, 8'h03, 8'h07, 8'h00, 8'h09, 16'h07e0}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL},
      {{FUNC_NEXT,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}, ROW_PREDICT, NO_PIXEL}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   bresenham_line_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // predictor state
   bit          line_on;
   bit          along_x;
   bit          minor_down;
   logic [7:0]  major_at;
   logic [7:0]  minor_at;
   int          steps_left;
   int          decision;
   int          major_inc;
   int          minor_inc;
   logic [15:0] line_colour;

   rsp_payload_type pending_pixels [$];
   rsp_payload_type seen_pixel;
   rsp_payload_type want_pixel;

   int unsigned cycle_count;
   int unsigned live_requests;
   int unsigned burst_left;
   int unsigned mismatches;
   int unsigned n_starts;
   int unsigned n_degenerate;
   int unsigned n_pixels;
   int unsigned n_line_ends;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                  pending_pixels.size());
         $display("bresenham_line_generator verification failed");
         $finish;
      end
   end

   function automatic int coord_span(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   // next pixel of the line, or the coincident-endpoint response
   task automatic rasterise_request(input req_payload_type p, output bit produced,
                                    output rsp_payload_type pix);
      int         span_x;
      int         span_y;
      int         span_major;
      int         span_minor;
      logic [7:0] major_from;
      logic [7:0] minor_from;
      logic [7:0] minor_to;
      produced = 1'b0;
      pix      = '0;
      if (p.func == FUNC_START || line_on)
         live_requests++;
      if (p.func == FUNC_START) begin
         n_starts++;
         span_x      = coord_span(p.x_start, p.x_end);
         span_y      = coord_span(p.y_start, p.y_end);
         line_colour = p.pixel_color;
         along_x     = span_x > span_y;
         if (along_x) begin
            if (p.x_start > p.x_end) begin
               major_from = p.x_end;
               minor_from = p.y_end;
               minor_to   = p.y_start;
            end else begin
               major_from = p.x_start;
               minor_from = p.y_start;
               minor_to   = p.y_end;
            end
            span_major = span_x;
            span_minor = span_y;
         end else begin
            if (p.y_start > p.y_end) begin
               major_from = p.y_end;
               minor_from = p.x_end;
               minor_to   = p.x_start;
            end else begin
               major_from = p.y_start;
               minor_from = p.x_start;
               minor_to   = p.x_end;
            end
            span_major = span_y;
            span_minor = span_x;
         end
         if (span_major == 0) begin
            line_on              = 1'b0;
            pix.degenerate_error = 1'b1;
            produced             = 1'b1;
            n_degenerate++;
         end else begin
            minor_down = !(minor_to > minor_from);
            major_at   = major_from;
            minor_at   = minor_from;
            steps_left = span_major;
            major_inc  = 2 * span_major;
            minor_inc  = 2 * span_minor;
            decision   = minor_inc - span_major;
            line_on    = 1'b1;
         end
      end else if (line_on) begin
         produced       = 1'b1;
         pix.out_x      = along_x ? major_at : minor_at;
         pix.out_y      = along_x ? minor_at : major_at;
         pix.out_color  = line_colour;
         pix.last_pixel = (steps_left == 0);
         if (steps_left == 0) begin
            line_on = 1'b0;
         end else begin
            if (decision >= 0) begin
               minor_at = minor_down ? minor_at - 8'd1 : minor_at + 8'd1;
               decision -= major_inc;
            end
            decision += minor_inc;
            major_at++;
            steps_left--;
         end
      end
   endtask

   // offer one request, wait for it to be taken, then record what it should give
   task automatic offer_request(input req_payload_type p, input row_kind_type kind,
                                input rsp_payload_type typed_pixel);
      bit              produced;
      rsp_payload_type pix;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);
      rasterise_request(p, produced, pix);
      case (kind)
         ROW_PREDICT: begin
            if (produced)
               pending_pixels.push_back(pix);
         end
         ROW_FIXED: begin
            pending_pixels.push_back(typed_pixel);
         end
         default: begin
         end
      endcase
   endtask

   function automatic req_payload_type random_request();
      req_payload_type p;
      p.func        = 1'($urandom_range(0, 1));
      p.x_start     = 8'($urandom_range(0, 255));
      p.y_start     = 8'($urandom_range(0, 255));
      p.x_end       = 8'($urandom_range(0, 255));
      p.y_end       = 8'($urandom_range(0, 255));
      p.pixel_color = 16'($urandom_range(0, 65535));
      return p;
   endfunction

   function automatic logic [7:0] near_coord(input logic [7:0] c, input int reach);
      int d;
      int t;
      d = $urandom_range(0, 2 * reach);
      d = d - reach;
      t = int'(c) + d;
      if (t < 0 || t > 255)
         t = int'(c) - d;
      return t[7:0];
   endfunction

   // mostly a start followed by enough next requests to finish the line
   task automatic random_sequence();
      req_payload_type p;
      int              pick;
      int              reach;
      int              n_next;
      pick = $urandom_range(0, 99);
      p    = random_request();
      if (pick < 8) begin
         p.func  = FUNC_START;
         p.x_end = p.x_start;
         p.y_end = p.y_start;
         offer_request(p, ROW_PREDICT, NO_PIXEL);
      end else if (pick < 12) begin
         p.func = FUNC_NEXT;
         offer_request(p, ROW_PREDICT, NO_PIXEL);
      end else begin
         p.func = FUNC_START;
         if (pick < 20) begin
            p.x_start = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.y_start = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.x_end   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.y_end   = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end else if (pick >= 28) begin
            reach   = $urandom_range(1, 12);
            p.x_end = near_coord(p.x_start, reach);
            p.y_end = near_coord(p.y_start, reach);
         end
         offer_request(p, ROW_PREDICT, NO_PIXEL);
         n_next = coord_span(p.x_start, p.x_end);
         if (coord_span(p.y_start, p.y_end) > n_next)
            n_next = coord_span(p.y_start, p.y_end);
         n_next = n_next + 1;
         pick = $urandom_range(0, 99);
         if (pick < 12)
            n_next = $urandom_range(0, n_next - 1);
         else if (pick < 25)
            n_next = n_next + $urandom_range(1, 3);
         repeat (n_next) begin
            p      = random_request();
            p.func = FUNC_NEXT;
            offer_request(p, ROW_PREDICT, NO_PIXEL);
         end
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // response checker, sampled mid-cycle so the handshake is settled
   always @(negedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         seen_pixel = rsp_payload;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response x=0x%0h y=0x%0h colour=0x%0h last=%0b err=%0b",
                     $time, seen_pixel.out_x, seen_pixel.out_y, seen_pixel.out_color,
                     seen_pixel.last_pixel, seen_pixel.degenerate_error);
         end else begin
            want_pixel = pending_pixels.pop_front();
            check_field("out_x", want_pixel.out_x, seen_pixel.out_x);
            check_field("out_y", want_pixel.out_y, seen_pixel.out_y);
            check_field("out_color", want_pixel.out_color, seen_pixel.out_color);
            check_field("last_pixel", want_pixel.last_pixel, seen_pixel.last_pixel);
            check_field("degenerate_error", want_pixel.degenerate_error,
                        seen_pixel.degenerate_error);
            if (!seen_pixel.degenerate_error)
               n_pixels++;
            if (seen_pixel.last_pixel)
               n_line_ends++;
         end
      end
   end

   // receiver: switches between four stall styles, plus one long hold-off
   initial begin
      int unsigned recv_cycles;
      int unsigned hold_left;
      int unsigned recv_mode;
      recv_cycles = 0;
      hold_left   = 0;
      recv_mode   = 0;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         recv_cycles++;
         if (recv_cycles == HOLD_START)
            hold_left = HOLD_CYCLES;
         if (recv_cycles % 64 == 0)
            recv_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (recv_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (recv_cycles % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].rsp);
      while (live_requests < TARGET_REQUESTS)
         random_sequence();
      req_valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         mismatches++;
         $display("%0d expected responses never arrived", pending_pixels.size());
      end
      $display("%0d live requests: %0d line starts (%0d with coincident endpoints),",
               live_requests, n_starts, n_degenerate);
      $display("%0d pixels checked, %0d line ends, %0d mismatches", n_pixels, n_line_ends,
               mismatches);
      if (mismatches == 0)
         $display("bresenham_line_generator verification clean");
      else
         $display("bresenham_line_generator verification failed");
      $finish;
   end

endmodule
